// ===== rtl/fifo_with_priority_reorder_top_assert.svh =====
// Assertion macros for the priority-reorder FIFO.
// Used by fwpr_dp.sv; needs no other file.
`ifndef FIFO_WITH_PRIORITY_REORDER_TOP_ASSERT_SVH
`define FIFO_WITH_PRIORITY_REORDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FWPR_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("fwpr assertion failed");

// Next-cycle implication, disabled during reset.
`define FWPR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("fwpr assertion failed");

`endif

// ===== rtl/fwpr_pkg.sv =====
// Shared types and constants of the priority-reorder FIFO.
// No dependencies.
package fwpr_pkg;

    localparam int DEF_CAPACITY = 128;

    typedef enum logic [1:0] {
        ACT_INS   = 2'd0,
        ACT_POP   = 2'd1,
        ACT_SORT  = 2'd2,
        ACT_QUERY = 2'd3
    } t_act;

    typedef struct packed {
        t_act        action;
        logic [31:0] in_id;
        logic [7:0]  in_key;
    } t_req;

    typedef struct packed {
        logic [31:0] out_id;
        logic [7:0]  out_key;
        logic        out_valid;
        logic        accepted;
        logic [7:0]  occupancy;
        logic        is_full;
        logic        is_empty;
    } t_res;

    typedef enum logic [1:0] {
        RS_HEAD,
        RS_I,
        RS_JM1
    } t_rsel;

    typedef enum logic [1:0] {
        WS_NONE,
        WS_INS,
        WS_SHIFT,
        WS_TEMP
    } t_wsel;

    typedef struct packed {
        logic  load;
        t_rsel rd_sel;
        t_wsel wr_sel;
        logic  do_ins;
        logic  do_pop;
        logic  init_i;
        logic  ld_temp;
        logic  next_i;
        logic  dec_j;
        logic  out_en;
        logic  out_pop;
    } t_cmd;

    typedef struct packed {
        logic cnt_lt2;
        logic last_i;
        logic j_zero;
        logic key_less;
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_HEAD,
        S_EXEC,
        S_SORT_RDI,
        S_SORT_LDI,
        S_SORT_RDJ,
        S_SORT_CMP,
        S_RD_NEW,
        S_OUT
    } t_state;

endpackage

// ===== rtl/fwpr_dp.sv =====
// Datapath: entry memory, head pointer, fill count, sort indexes and result register.
// Depends on fwpr_pkg and fifo_with_priority_reorder_top_assert.svh.
`include "fifo_with_priority_reorder_top_assert.svh"
module fwpr_dp import fwpr_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output t_res  o_res
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    logic [31:0]   r_mem_id  [CAPACITY];
    logic [7:0]    r_mem_key [CAPACITY];
    logic [31:0]   r_rd_id;
    logic [7:0]    r_rd_key;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, r_j;
    logic [31:0]   r_tid, r_hid;
    logic [7:0]    r_tkey, r_hkey;
    logic          r_hvalid, r_acc;
    t_res          r_res;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [31:0]   wr_id;
    logic [7:0]    wr_key;
    logic          full, zero;

    function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(CAPACITY)) begin
            s = s - SW'(CAPACITY);
        end
        return AW'(s);
    endfunction

    assign full = (r_cnt == CW'(CAPACITY));
    assign zero = (r_cnt == '0);

    always_comb begin
        case (i_cmd.rd_sel)
            RS_HEAD: rd_addr = r_head;
            RS_I:    rd_addr = mod_add(r_head, r_i);
            RS_JM1:  rd_addr = mod_add(r_head, r_j - CW'(1));
            default: rd_addr = r_head;
        endcase
        wr_addr = mod_add(r_head, r_j);
        wr_id   = r_tid;
        wr_key  = r_tkey;
        case (i_cmd.wr_sel)
            WS_INS: begin
                wr_addr = mod_add(r_head, r_cnt);
                wr_id   = r_tid;
                wr_key  = r_tkey;
            end
            WS_SHIFT: begin
                wr_id  = r_rd_id;
                wr_key = r_rd_key;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_id  <= r_mem_id[rd_addr];
        r_rd_key <= r_mem_key[rd_addr];
        // drop rejected inserts
        if ((i_cmd.wr_sel == WS_SHIFT) || (i_cmd.wr_sel == WS_TEMP)
            || ((i_cmd.wr_sel == WS_INS) && !full)) begin
            r_mem_id[wr_addr]  <= wr_id;
            r_mem_key[wr_addr] <= wr_key;
        end
    end

    always_comb begin
        n_head = r_head;
        n_cnt  = r_cnt;
        if (i_cmd.do_ins && !full) begin
            n_cnt = r_cnt + CW'(1);
        end
        if (i_cmd.do_pop && !zero) begin
            n_head = mod_add(r_head, CW'(1));
            n_cnt  = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tid    <= i_req.in_id;
            r_tkey   <= i_req.in_key;
            r_acc    <= 1'b0;
            r_hvalid <= 1'b0;
            r_hid    <= '0;
            r_hkey   <= '0;
        end
        if (i_cmd.do_ins) begin
            r_acc <= !full;
        end
        if (i_cmd.do_pop && !zero) begin
            r_acc    <= 1'b1;
            r_hvalid <= 1'b1;
            r_hid    <= r_rd_id;
            r_hkey   <= r_rd_key;
        end
        if (i_cmd.init_i) begin
            r_i <= CW'(1);
        end
        if (i_cmd.next_i) begin
            r_i <= r_i + CW'(1);
        end
        if (i_cmd.ld_temp) begin
            r_tid  <= r_rd_id;
            r_tkey <= r_rd_key;
            r_j    <= r_i;
        end
        if (i_cmd.dec_j) begin
            r_j <= r_j - CW'(1);
        end
        if (i_cmd.out_en) begin
            if (i_cmd.out_pop) begin
                r_res.out_id    <= r_hid;
                r_res.out_key   <= r_hkey;
                r_res.out_valid <= r_hvalid;
            end else begin
                r_res.out_id    <= zero ? 32'd0 : r_rd_id;
                r_res.out_key   <= zero ? 8'd0 : r_rd_key;
                r_res.out_valid <= !zero;
            end
            r_res.accepted  <= r_acc;
            r_res.occupancy <= 8'(r_cnt);
            r_res.is_full   <= full;
            r_res.is_empty  <= zero;
        end
    end

    assign o_stat.cnt_lt2  = (r_cnt < CW'(2));
    assign o_stat.last_i   = ((r_i + CW'(1)) == r_cnt);
    assign o_stat.j_zero   = (r_j == '0);
    assign o_stat.key_less = (r_rd_key < r_tkey);
    assign o_res = r_res;

    `FWPR_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(CAPACITY))
    `FWPR_ASSERT_NXT(a_pop_dec, i_clk, i_rst_n, i_cmd.do_pop && !zero,
        r_cnt == $past(r_cnt) - CW'(1))
    `FWPR_ASSERT_NXT(a_full_hold, i_clk, i_rst_n, i_cmd.do_ins && full, $stable(r_cnt))
endmodule

// ===== rtl/fwpr_ctrl.sv =====
// Controller state machine: sequences insert, pop, query and the insertion sort.
// Depends on fwpr_pkg.
module fwpr_ctrl import fwpr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_act  i_action,
    input  t_stat i_stat,
    output logic  busy,
    output logic  o_done,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    t_act   r_act, n_act;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= ACT_QUERY;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
            r_done  <= o_cmd.out_en;
        end
    end

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        busy    = 1'b1;
        o_cmd   = '0;
        o_cmd.rd_sel = RS_HEAD;
        o_cmd.wr_sel = WS_NONE;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_act      = i_action;
                    n_state    = S_RD_HEAD;
                end
            end
            S_RD_HEAD: n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_RD_NEW;
                case (r_act)
                    ACT_INS: begin
                        o_cmd.do_ins = 1'b1;
                        o_cmd.wr_sel = WS_INS;
                    end
                    ACT_POP: o_cmd.do_pop = 1'b1;
                    ACT_SORT: begin
                        if (!i_stat.cnt_lt2) begin
                            o_cmd.init_i = 1'b1;
                            n_state      = S_SORT_RDI;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SORT_RDI: begin
                o_cmd.rd_sel = RS_I;
                n_state      = S_SORT_LDI;
            end
            S_SORT_LDI: begin
                o_cmd.ld_temp = 1'b1;
                n_state       = S_SORT_RDJ;
            end
            S_SORT_RDJ: begin
                if (i_stat.j_zero) begin
                    o_cmd.wr_sel = WS_TEMP;
                    o_cmd.next_i = 1'b1;
                    n_state      = i_stat.last_i ? S_RD_NEW : S_SORT_RDI;
                end else begin
                    o_cmd.rd_sel = RS_JM1;
                    n_state      = S_SORT_CMP;
                end
            end
            S_SORT_CMP: begin
                // shift the smaller key up, else drop the held entry in place
                if (i_stat.key_less) begin
                    o_cmd.wr_sel = WS_SHIFT;
                    o_cmd.dec_j  = 1'b1;
                    n_state      = S_SORT_RDJ;
                end else begin
                    o_cmd.wr_sel = WS_TEMP;
                    o_cmd.next_i = 1'b1;
                    n_state      = i_stat.last_i ? S_RD_NEW : S_SORT_RDI;
                end
            end
            S_RD_NEW: n_state = S_OUT;
            S_OUT: begin
                o_cmd.out_en  = 1'b1;
                o_cmd.out_pop = (r_act == ACT_POP);
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_done = r_done;
endmodule

// ===== rtl/fifo_with_priority_reorder_top.sv =====
// Top level of the priority-reorder FIFO: controller plus datapath.
// Depends on fwpr_pkg, fwpr_ctrl and fwpr_dp.
//
// Usage:
//   A request (action, id, key on i_req) is taken at a clock edge where start
//   is high and busy is low. Actions: insert at tail, pop head, stable sort by
//   key descending, query.
//   One result per request appears on o_res with o_done high for exactly one
//   cycle; the receiver cannot stall it and must take it in that cycle.
//   Insert, pop and query step through S_RD_HEAD, S_EXEC, S_RD_NEW and S_OUT
//   before o_done rises; busy is high through them, so a new request is taken
//   only once the previous one is finished and the controller is in S_IDLE.
//   A sort runs an insertion sort through the single-read entry memory: each
//   compare step reads in S_SORT_RDJ and compares and writes in S_SORT_CMP,
//   as the one memory read port gives one entry per read.
//   The result for a request is registered, so the next request may be
//   accepted in the cycle its result is shown.
//   Reset (synchronous, active low) empties the FIFO at once; the entry
//   memory itself is not cleared and needs no clearing pass.
module fifo_with_priority_reorder_top import fwpr_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_res
);
    t_cmd  cmd;
    t_stat stat;

    fwpr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_req.action),
        .i_stat   (stat),
        .busy     (busy),
        .o_done   (o_done),
        .o_cmd    (cmd)
    );

    fwpr_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res)
    );
endmodule
